[rtl/thpc_pkg.sv]
// Shared types, fixed-point widths and constants for the target heading controller.
// Used by every module of the block; depends on nothing.
package thpc_pkg;

  // Step count of the arctangent pipeline (8 to 24) and the x dead band in Q11.8 counts.
  localparam int CORDIC_STEPS = 16;
  localparam int X_DEADBAND   = 2;

  // Field widths
  localparam int XW      = 20;            // offsets, Q11.8
  localparam int SCALE   = 20;            // operand pre-scale of the vectoring loop
  localparam int CW      = 43;            // vectoring x/y, room for the CORDIC growth
  localparam int ZW      = 34;            // angle accumulator, Q2.30 plus headroom
  localparam int AW      = 16;            // angle error, Q2.13
  localparam int TOL_W   = 15;
  localparam int GAIN_W  = 16;
  localparam int RATE_W  = 20;            // turn rate, Q7.12
  localparam int MAG_W   = 19;
  localparam int PROD_W  = 33;            // gain * error, Q10.21
  localparam int OMG_W   = 24;
  localparam int KIND_W  = 3;
  localparam int STEP_W  = 5;
  localparam int TABLE_LEN = 24;

  // Angle constants
  localparam int ANGLE_PI   = 25736;
  localparam int ZSHIFT     = 17;         // Q2.30 -> Q2.13
  localparam int PROD_SHIFT = 9;          // Q10.21 -> Q7.12

  localparam logic signed [ZW-1:0] PI_Z      = ZW'(64'(ANGLE_PI) << ZSHIFT);
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'(1) << (ZSHIFT - 1));
  localparam logic signed [ZW-1:0] Z_PI_LIM  = ZW'(ANGLE_PI);
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1 << (PROD_SHIFT - 1));
  localparam logic signed [XW-1:0] X_DB      = XW'(X_DEADBAND);

  // Arctangent of 2^-i, radians Q2.30, truncated
  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KIND      = 3'd0,
    REG_GAIN      = 3'd1,
    REG_TOLERANCE = 3'd2,
    REG_MIN_RATE  = 3'd3,
    REG_MAX_RATE  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [KIND_W-1:0] wanted_target_kind;
    logic [GAIN_W-1:0] angle_gain;
    logic [TOL_W-1:0]  angle_tolerance;
    logic [MAG_W-1:0]  min_turn_rate;
    logic [MAG_W-1:0]  max_turn_rate;
  } cfg_t;

  typedef struct packed {
    logic                 target_present;
    logic [KIND_W-1:0]    target_kind;
    logic signed [XW-1:0] x_offset;
    logic signed [XW-1:0] y_offset;
  } req_t;

  typedef struct packed {
    logic                     apply_turn;
    logic signed [RATE_W-1:0] turn_rate;
    logic                     at_target;
  } rsp_t;

  // Vectoring pipeline word
  typedef struct packed {
    logic                 active;   // present and of the wanted kind
    logic                 deadband; // |x| inside the dead band
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic                 active;
    logic                 deadband;
    logic signed [AW-1:0] err;
  } ang_t;

  typedef struct packed {
    logic                     active;
    logic                     deadband;
    logic                     in_band;
    logic signed [PROD_W-1:0] prod;
  } prd_t;

  typedef struct packed {
    logic                     active;
    logic                     deadband;
    logic                     in_band;
    logic                     neg;
    logic [OMG_W-2:0]         mag;
  } omg_t;

  // One vectoring iteration: rotate toward y = 0, a zero y counts as positive
  function automatic vec_t cordic_step(vec_t a, logic [STEP_W-1:0] idx);
    vec_t                 r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] t;
    r  = a;
    dx = a.y >>> idx;
    dy = a.x >>> idx;
    t  = $signed({{(ZW-32){1'b0}}, ATAN_Q30[idx]});
    if (!a.y[CW-1]) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + t;
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - t;
    end
    return r;
  endfunction

endpackage

[rtl/thpc_front.sv]
// Entry stage: qualifies the request, checks the x dead band and pre-rotates a negative x by pi.
// Depends on thpc_pkg.
module thpc_front import thpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  req_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output vec_t dn_data
);

  logic                 valid;
  vec_t                 data;
  vec_t                 data_next;
  logic signed [XW:0]   xe;
  logic signed [XW:0]   ye;

  // Qualify, fold the left half plane and scale up for the vectoring loop
  always_comb begin
    xe = {up_data.x_offset[XW-1], up_data.x_offset};
    ye = {up_data.y_offset[XW-1], up_data.y_offset};
    data_next.active = up_data.target_present &&
                       (up_data.target_kind == cfg.wanted_target_kind);
    data_next.deadband = (up_data.x_offset <= X_DB) && (up_data.x_offset >= -X_DB);
    data_next.z      = '0;
    if (xe[XW]) begin
      data_next.z = ye[XW] ? -PI_Z : PI_Z;
      xe = -xe;
      ye = -ye;
    end
    data_next.x = {{(CW-XW-1-SCALE){xe[XW]}}, xe, {SCALE{1'b0}}};
    data_next.y = {{(CW-XW-1-SCALE){ye[XW]}}, ye, {SCALE{1'b0}}};
  end

  assign up_ready = !valid || dn_ready;

  // Advance when the next stage takes our word or we hold none
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

[rtl/thpc_cordic.sv]
// Unrolled vectoring CORDIC: one iteration and one register stage per step.
// Depends on thpc_pkg (cordic_step, arctangent table).
module thpc_cordic import thpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  vec_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output vec_t dn_data
);

  logic valid [CORDIC_STEPS];
  vec_t data  [CORDIC_STEPS];
  logic rdy   [CORDIC_STEPS+1];

  assign rdy[CORDIC_STEPS] = dn_ready;
  assign up_ready          = rdy[0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic src_valid;
    vec_t src_data;

    if (i == 0) begin : g_first
      assign src_valid = up_valid;
      assign src_data  = up_data;
    end else begin : g_rest
      assign src_valid = valid[i-1];
      assign src_data  = data[i-1];
    end

    // Stage takes a word when empty or when its word moves on
    assign rdy[i] = !valid[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (rdy[i]) begin
        valid[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_valid) begin
        data[i] <= cordic_step(src_data, STEP_W'(i));
      end
    end
  end

  assign dn_valid = valid[CORDIC_STEPS-1];
  assign dn_data  = data[CORDIC_STEPS-1];

endmodule

[rtl/thpc_back.sv]
// Back end: angle rounding and clamp, gain multiply, rate rounding, min/max clamp, result register.
// Depends on thpc_pkg.
module thpc_back import thpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  vec_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output rsp_t dn_data
);

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;
  ang_t s1, s1_next;
  prd_t s2, s2_next;
  omg_t s3, s3_next;
  rsp_t s4, s4_next;

  logic signed [ZW-1:0]     zr;
  logic signed [AW-1:0]     err_abs;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [OMG_W-1:0]  omega;
  logic [OMG_W-1:0]         omega_abs;
  logic [OMG_W-2:0]         mag_lo;
  logic [MAG_W-1:0]         mag;

  // Ready chain, last stage is the result register
  assign r4 = !v4 || dn_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;

  // Round Q2.30 half up to Q2.13 and clamp to +-pi; the dead band forces zero
  always_comb begin
    zr = (up_data.z + Z_HALF) >>> ZSHIFT;
    if (zr > Z_PI_LIM) begin
      zr = Z_PI_LIM;
    end else if (zr < -Z_PI_LIM) begin
      zr = -Z_PI_LIM;
    end
    s1_next.active   = up_data.active;
    s1_next.deadband = up_data.deadband;
    s1_next.err      = up_data.deadband ? '0 : AW'(zr);
  end

  // Multiply by the gain and test the tolerance band
  always_comb begin
    err_abs          = s1.err[AW-1] ? -s1.err : s1.err;
    s2_next.active   = s1.active;
    s2_next.deadband = s1.deadband;
    s2_next.in_band  = ({1'b0, err_abs[AW-2:0]} < {1'b0, cfg.angle_tolerance});
    s2_next.prod     = $signed({1'b0, cfg.angle_gain}) * s1.err;
  end

  // Round to Q7.12 and split into sign and magnitude (zero is positive)
  always_comb begin
    prod_r           = (s2.prod + PROD_HALF) >>> PROD_SHIFT;
    omega            = prod_r[OMG_W-1:0];
    omega_abs        = omega[OMG_W-1] ? OMG_W'(-omega) : OMG_W'(omega);
    s3_next.active   = s2.active;
    s3_next.deadband = s2.deadband;
    s3_next.in_band  = s2.in_band;
    s3_next.neg      = omega[OMG_W-1];
    s3_next.mag      = omega_abs[OMG_W-2:0];
  end

  // Raise to the minimum, cut to the maximum, then build the result
  always_comb begin
    mag_lo = (s3.mag < (OMG_W-1)'(cfg.min_turn_rate)) ?
             (OMG_W-1)'(cfg.min_turn_rate) : s3.mag;
    mag    = (mag_lo > (OMG_W-1)'(cfg.max_turn_rate)) ?
             cfg.max_turn_rate : mag_lo[MAG_W-1:0];
    s4_next.apply_turn = 1'b0;
    s4_next.turn_rate  = '0;
    s4_next.at_target  = 1'b0;
    if (s3.active) begin
      if (!s3.deadband && s3.in_band) begin
        s4_next.at_target = 1'b1;
      end else begin
        s4_next.apply_turn = 1'b1;
        s4_next.turn_rate  = s3.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (r1 && up_valid) s1 <= s1_next;
    if (r2 && v1)       s2 <= s2_next;
    if (r3 && v2)       s3 <= s3_next;
    if (r4 && v3)       s4 <= s4_next;
  end

  assign dn_valid = v4;
  assign dn_data  = s4;

endmodule

[rtl/target_heading_p_controller.sv]
// Top level of the target heading controller: configuration registers and the pipeline.
// Depends on thpc_pkg, thpc_front, thpc_cordic and thpc_back.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one vision report per request,
//   taken at a rising edge with req_valid high and req_stall low.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one result per request,
//   in request order, taken at a rising edge with rsp_valid high and rsp_stall low.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; indexes beyond the register list are dropped. Write only when idle.
// Pipeline: 21 register stages, one entry stage, one per CORDIC step (16), and four
//   back-end stages (round, multiply, rate round, clamp).
// Throughput: one request per cycle while req_stall is low; each pipeline stage holds
//   one CORDIC iteration or one add/multiply.
// Reset (rst, synchronous): clears every valid bit and loads the register defaults.
// Stall: rsp_stall holds the result register; empty stages upstream keep filling,
//   and req_stall rises only once every stage holds a request.
module target_heading_p_controller import thpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [MAG_W-1:0] cfg_data
);

  cfg_t cfg;
  logic front_ready, front_valid;
  vec_t front_data;
  logic cordic_ready, cordic_valid;
  vec_t cordic_data;
  logic back_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wanted_target_kind <= KIND_W'(1);
      cfg.angle_gain         <= GAIN_W'(256);
      cfg.angle_tolerance    <= TOL_W'(410);
      cfg.min_turn_rate      <= '0;
      cfg.max_turn_rate      <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KIND:      cfg.wanted_target_kind <= cfg_data[KIND_W-1:0];
        REG_GAIN:      cfg.angle_gain         <= cfg_data[GAIN_W-1:0];
        REG_TOLERANCE: cfg.angle_tolerance    <= cfg_data[TOL_W-1:0];
        REG_MIN_RATE:  cfg.min_turn_rate      <= cfg_data;
        REG_MAX_RATE:  cfg.max_turn_rate      <= cfg_data;
        default: ;
      endcase
    end
  end

  thpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (req_valid),
    .up_ready (front_ready),
    .up_data  (req),
    .dn_valid (front_valid),
    .dn_ready (cordic_ready),
    .dn_data  (front_data)
  );

  thpc_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .up_valid (front_valid),
    .up_ready (cordic_ready),
    .up_data  (front_data),
    .dn_valid (cordic_valid),
    .dn_ready (back_ready),
    .dn_data  (cordic_data)
  );

  thpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (cordic_valid),
    .up_ready (back_ready),
    .up_data  (cordic_data),
    .dn_valid (rsp_valid),
    .dn_ready (!rsp_stall),
    .dn_data  (rsp)
  );

  assign req_stall = !front_ready;

endmodule

[rtl/thpc_check.sv]
// Port-level checker for the target heading controller, bound to the top level.
// Depends on thpc_pkg.
module thpc_check import thpc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // A result either drives a turn or reports at-target, never both
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.apply_turn && rsp.at_target))
    else $error("turn applied while at target");

  // No turn means a zero rate
  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.apply_turn) |-> (rsp.turn_rate == '0))
    else $error("nonzero rate without apply_turn");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  // Stall requests only while a response waits on a stalled receiver
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("unexpected request stall");

endmodule

bind target_heading_p_controller thpc_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
